[rtl/dtc_pkg.sv]
package dtc_pkg;

    typedef struct packed {
        logic        kind;
        logic [6:0]  year_in;
        logic [3:0]  month_in;
        logic [4:0]  day_in;
        logic [4:0]  hour_in;
        logic [5:0]  minute_in;
        logic [5:0]  second_in;
        logic [31:0] seconds_in;
    } t_in_req;

    typedef struct packed {
        logic [31:0] seconds_out;
        logic [6:0]  year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic [4:0]  hour_out;
        logic [5:0]  minute_out;
        logic [5:0]  second_out;
    } t_out_rsp;

    typedef enum logic {
        KIND_TO_SECS = 1'b0,
        KIND_TO_DATE = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_YEAR,
        ST_MONTH,
        ST_DAY,
        ST_HOUR,
        ST_MIN,
        ST_SCALE,
        ST_DONE
    } t_state;

    // steps that turn a day count into seconds with the shared adder
    typedef enum logic [2:0] {
        SC_DAY,
        SC_MUL24,
        SC_HOUR,
        SC_MUL60A,
        SC_MIN,
        SC_MUL60B,
        SC_SEC
    } t_scale;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic        sub;
    } t_alu_req;

    typedef struct packed {
        logic [31:0] res;
        logic        borrow;
    } t_alu_rsp;

    typedef struct packed {
        logic ready;
        logic done;
    } t_seq_stat;

    // year offsets are counted from 1970
    localparam logic [7:0]  YOFF_2000      = 8'd30;
    localparam logic [7:0]  YOFF_2100      = 8'd130;
    localparam logic [1:0]  LEAP_PHASE     = 2'd2;
    localparam logic [6:0]  EPOCH_CENT     = 7'd70;
    localparam logic [6:0]  CENT_LAST      = 7'd99;
    localparam logic [6:0]  YEAR_IN_MAX    = 7'd99;
    localparam logic [3:0]  LAST_MONTH     = 4'd12;
    localparam logic [4:0]  HOUR_MAX       = 5'd23;
    localparam logic [5:0]  MINSEC_MAX     = 6'd59;
    localparam logic [31:0] YEAR_DAYS      = 32'd365;
    localparam logic [31:0] LEAP_DAYS      = 32'd366;
    localparam logic [31:0] YEAR_SECS      = 32'd31536000;
    localparam logic [31:0] LEAP_YEAR_SECS = 32'd31622400;
    localparam logic [31:0] SECS_PER_DAY   = 32'd86400;
    localparam logic [31:0] SECS_PER_HOUR  = 32'd3600;
    localparam logic [31:0] SECS_PER_MIN   = 32'd60;

    // 2000 is a leap year, 2100 is the only century year in range that is not
    function automatic logic is_leap(input logic [7:0] yoff);
        return (yoff[1:0] == LEAP_PHASE) && (yoff != YOFF_2100);
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] md;
        if (m == 4'd2) begin
            md = leap ? 5'd29 : 5'd28;
        end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
            md = 5'd30;
        end else begin
            md = 5'd31;
        end
        return md;
    endfunction

    function automatic logic [31:0] days_to_secs(input logic [4:0] md);
        logic [31:0] s;
        case (md)
            5'd28: s = 32'd2419200;
            5'd29: s = 32'd2505600;
            5'd30: s = 32'd2592000;
            default: s = 32'd2678400;
        endcase
        return s;
    endfunction

endpackage

[rtl/dtc_alu.sv]
module dtc_alu (
    input  dtc_pkg::t_alu_req i_req,
    output dtc_pkg::t_alu_rsp o_rsp
);

    logic [32:0] sum;

    // subtract as a + ~b + 1; a clear carry out means a < b
    always_comb begin
        if (i_req.sub) begin
            sum = {1'b0, i_req.a} + {1'b0, ~i_req.b} + 33'd1;
        end else begin
            sum = {1'b0, i_req.a} + {1'b0, i_req.b};
        end
        o_rsp.res    = sum[31:0];
        o_rsp.borrow = i_req.sub & ~sum[32];
    end

endmodule

[rtl/dtc_seq.sv]
module dtc_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  dtc_pkg::t_in_req   i_req,
    input  logic               i_load,
    output dtc_pkg::t_seq_stat o_stat,
    output dtc_pkg::t_out_rsp  o_rsp,
    output dtc_pkg::t_alu_req  o_alu_req,
    input  dtc_pkg::t_alu_rsp  i_alu_rsp
);

    dtc_pkg::t_state r_state, n_state;
    dtc_pkg::t_scale r_step, n_step;
    logic        r_kind, n_kind;
    logic [31:0] r_acc, n_acc;
    logic [7:0]  r_yoff, n_yoff;
    logic [7:0]  r_yoff_tgt, n_yoff_tgt;
    logic [6:0]  r_ycent, n_ycent;
    logic [3:0]  r_month, n_month;
    logic [3:0]  r_mo_lim, n_mo_lim;
    logic [4:0]  r_day, n_day;
    logic [4:0]  r_hour, n_hour;
    logic [5:0]  r_min, n_min;
    logic [4:0]  r_dm1, n_dm1;
    logic [4:0]  r_hr, n_hr;
    logic [5:0]  r_mi, n_mi;
    logic [5:0]  r_se, n_se;

    logic       to_date;
    logic       leap;
    logic [4:0] md;

    assign to_date = (r_kind == dtc_pkg::KIND_TO_DATE);
    assign leap    = dtc_pkg::is_leap(r_yoff);
    assign md      = dtc_pkg::month_days(r_month, leap);

    always_comb begin
        n_state = r_state;
        case (r_state)
            dtc_pkg::ST_IDLE: begin
                if (i_start) n_state = dtc_pkg::ST_YEAR;
            end
            dtc_pkg::ST_YEAR: begin
                if (to_date ? i_alu_rsp.borrow : (r_yoff == r_yoff_tgt)) begin
                    n_state = dtc_pkg::ST_MONTH;
                end
            end
            dtc_pkg::ST_MONTH: begin
                if (to_date) begin
                    if (i_alu_rsp.borrow || r_month >= dtc_pkg::LAST_MONTH) begin
                        n_state = dtc_pkg::ST_DAY;
                    end
                end else if (r_month == r_mo_lim) begin
                    n_state = dtc_pkg::ST_SCALE;
                end
            end
            dtc_pkg::ST_DAY: begin
                if (i_alu_rsp.borrow) n_state = dtc_pkg::ST_HOUR;
            end
            dtc_pkg::ST_HOUR: begin
                if (i_alu_rsp.borrow) n_state = dtc_pkg::ST_MIN;
            end
            dtc_pkg::ST_MIN: begin
                if (i_alu_rsp.borrow) n_state = dtc_pkg::ST_DONE;
            end
            dtc_pkg::ST_SCALE: begin
                if (r_step == dtc_pkg::SC_SEC) n_state = dtc_pkg::ST_DONE;
            end
            dtc_pkg::ST_DONE: begin
                if (i_load) n_state = dtc_pkg::ST_IDLE;
            end
            default: n_state = dtc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_alu_req.a   = r_acc;
        o_alu_req.b   = '0;
        o_alu_req.sub = 1'b0;

        n_step     = r_step;
        n_kind     = r_kind;
        n_acc      = r_acc;
        n_yoff     = r_yoff;
        n_yoff_tgt = r_yoff_tgt;
        n_ycent    = r_ycent;
        n_month    = r_month;
        n_mo_lim   = r_mo_lim;
        n_day      = r_day;
        n_hour     = r_hour;
        n_min      = r_min;
        n_dm1      = r_dm1;
        n_hr       = r_hr;
        n_mi       = r_mi;
        n_se       = r_se;

        case (r_state)
            dtc_pkg::ST_IDLE: begin
                if (i_start) begin
                    // sanitize the date fields and clear the counters
                    n_kind  = i_req.kind;
                    n_acc   = (i_req.kind == dtc_pkg::KIND_TO_DATE) ? i_req.seconds_in : '0;
                    n_yoff  = '0;
                    n_ycent = dtc_pkg::EPOCH_CENT;
                    n_month = 4'd1;
                    n_day   = 5'd1;
                    n_hour  = '0;
                    n_min   = '0;
                    n_step  = dtc_pkg::SC_DAY;
                    n_yoff_tgt = dtc_pkg::YOFF_2000 + ((i_req.year_in > dtc_pkg::YEAR_IN_MAX)
                                 ? 8'd0 : {1'b0, i_req.year_in});
                    n_mo_lim = (i_req.month_in == 4'd0 || i_req.month_in > dtc_pkg::LAST_MONTH)
                               ? 4'd1 : i_req.month_in;
                    n_dm1 = (i_req.day_in == 5'd0) ? 5'd0 : i_req.day_in - 5'd1;
                    n_hr  = (i_req.hour_in > dtc_pkg::HOUR_MAX) ? 5'd0 : i_req.hour_in;
                    n_mi  = (i_req.minute_in > dtc_pkg::MINSEC_MAX) ? 6'd0 : i_req.minute_in;
                    n_se  = (i_req.second_in > dtc_pkg::MINSEC_MAX) ? 6'd0 : i_req.second_in;
                end
            end
            dtc_pkg::ST_YEAR: begin
                if (to_date) begin
                    o_alu_req.b   = leap ? dtc_pkg::LEAP_YEAR_SECS : dtc_pkg::YEAR_SECS;
                    o_alu_req.sub = 1'b1;
                    if (!i_alu_rsp.borrow) begin
                        n_acc   = i_alu_rsp.res;
                        n_yoff  = r_yoff + 8'd1;
                        n_ycent = (r_ycent == dtc_pkg::CENT_LAST) ? 7'd0 : r_ycent + 7'd1;
                    end
                end else begin
                    o_alu_req.b = leap ? dtc_pkg::LEAP_DAYS : dtc_pkg::YEAR_DAYS;
                    if (r_yoff != r_yoff_tgt) begin
                        n_acc  = i_alu_rsp.res;
                        n_yoff = r_yoff + 8'd1;
                    end
                end
            end
            dtc_pkg::ST_MONTH: begin
                if (to_date) begin
                    o_alu_req.b   = dtc_pkg::days_to_secs(md);
                    o_alu_req.sub = 1'b1;
                    if (!i_alu_rsp.borrow && r_month < dtc_pkg::LAST_MONTH) begin
                        n_acc   = i_alu_rsp.res;
                        n_month = r_month + 4'd1;
                    end
                end else begin
                    o_alu_req.b = {27'd0, md};
                    if (r_month != r_mo_lim) begin
                        n_acc   = i_alu_rsp.res;
                        n_month = r_month + 4'd1;
                    end
                end
            end
            dtc_pkg::ST_DAY: begin
                o_alu_req.b   = dtc_pkg::SECS_PER_DAY;
                o_alu_req.sub = 1'b1;
                if (!i_alu_rsp.borrow) begin
                    n_acc = i_alu_rsp.res;
                    n_day = r_day + 5'd1;
                end
            end
            dtc_pkg::ST_HOUR: begin
                o_alu_req.b   = dtc_pkg::SECS_PER_HOUR;
                o_alu_req.sub = 1'b1;
                if (!i_alu_rsp.borrow) begin
                    n_acc  = i_alu_rsp.res;
                    n_hour = r_hour + 5'd1;
                end
            end
            dtc_pkg::ST_MIN: begin
                o_alu_req.b   = dtc_pkg::SECS_PER_MIN;
                o_alu_req.sub = 1'b1;
                if (!i_alu_rsp.borrow) begin
                    n_acc = i_alu_rsp.res;
                    n_min = r_min + 6'd1;
                end
            end
            dtc_pkg::ST_SCALE: begin
                // x*24 = 16x + 8x, x*60 = 64x - 4x, wrapping at 32 bits
                case (r_step)
                    dtc_pkg::SC_DAY:  o_alu_req.b = {27'd0, r_dm1};
                    dtc_pkg::SC_MUL24: begin
                        o_alu_req.a = r_acc << 4;
                        o_alu_req.b = r_acc << 3;
                    end
                    dtc_pkg::SC_HOUR: o_alu_req.b = {27'd0, r_hr};
                    dtc_pkg::SC_MUL60A, dtc_pkg::SC_MUL60B: begin
                        o_alu_req.a   = r_acc << 6;
                        o_alu_req.b   = r_acc << 2;
                        o_alu_req.sub = 1'b1;
                    end
                    dtc_pkg::SC_MIN:  o_alu_req.b = {26'd0, r_mi};
                    dtc_pkg::SC_SEC:  o_alu_req.b = {26'd0, r_se};
                    default:          o_alu_req.b = '0;
                endcase
                n_acc = i_alu_rsp.res;
                if (r_step != dtc_pkg::SC_SEC) begin
                    n_step = dtc_pkg::t_scale'(r_step + 3'd1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dtc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step     <= n_step;
        r_kind     <= n_kind;
        r_acc      <= n_acc;
        r_yoff     <= n_yoff;
        r_yoff_tgt <= n_yoff_tgt;
        r_ycent    <= n_ycent;
        r_month    <= n_month;
        r_mo_lim   <= n_mo_lim;
        r_day      <= n_day;
        r_hour     <= n_hour;
        r_min      <= n_min;
        r_dm1      <= n_dm1;
        r_hr       <= n_hr;
        r_mi       <= n_mi;
        r_se       <= n_se;
    end

    assign o_stat.ready = (r_state == dtc_pkg::ST_IDLE);
    assign o_stat.done  = (r_state == dtc_pkg::ST_DONE);

    always_comb begin
        o_rsp = '0;
        if (to_date) begin
            o_rsp.year_out   = r_ycent;
            o_rsp.month_out  = r_month;
            o_rsp.day_out    = r_day;
            o_rsp.hour_out   = r_hour;
            o_rsp.minute_out = r_min;
            o_rsp.second_out = r_acc[5:0];
        end else begin
            o_rsp.seconds_out = r_acc;
        end
    end

endmodule

[rtl/datetime_epoch_seconds_converter_unit.sv]
// Converts between a date-time in the years 2000..2099 (two-digit year, month, day, hour,
// minute, second) and seconds since 1970-01-01 00:00:00 with Gregorian leap years; kind 1
// goes the other way and reports the year modulo 100. Out-of-range date fields are taken
// as in an RTC read path (bad year 0, bad month 1, day 0 as 1, bad time field 0). One 32-bit
// add/subtract unit serves every step, one step a cycle: date to seconds walks years and
// months, then scales the day, hour and minute fields up to seconds; seconds to date walks
// years, months, days, hours and minutes. A request is taken only when the unit is idle; a
// result waits in an output register, so the next request may start while it has not yet
// been taken.
module datetime_epoch_seconds_converter_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  dtc_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output dtc_pkg::t_out_rsp o_out_rsp
);

    dtc_pkg::t_seq_stat seq_stat;
    dtc_pkg::t_out_rsp  seq_rsp;
    dtc_pkg::t_alu_req  alu_req;
    dtc_pkg::t_alu_rsp  alu_rsp;

    logic              start;
    logic              load;
    logic              r_out_valid, n_out_valid;
    dtc_pkg::t_out_rsp r_out_rsp, n_out_rsp;

    assign start = i_in_valid && seq_stat.ready;
    // hold the finished result in the sequencer until the output register frees up
    assign load  = seq_stat.done && (!r_out_valid || i_out_ready);

    dtc_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    dtc_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_req     (i_in_req),
        .i_load    (load),
        .o_stat    (seq_stat),
        .o_rsp     (seq_rsp),
        .o_alu_req (alu_req),
        .i_alu_rsp (alu_rsp)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_rsp   = r_out_rsp;
        if (load) begin
            n_out_valid = 1'b1;
            n_out_rsp   = seq_rsp;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_rsp <= n_out_rsp;
    end

    assign o_in_ready  = seq_stat.ready;
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

endmodule
